>>> hdl/wss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the work-stealing slice scheduler.
// No dependencies; the files that use it refer to it by scoped names.
package wss_pkg;

  localparam int MAX_WORKERS_DEF = 8;
  localparam int SHL_FIRST_DEF = 13;
  localparam int SHR_SECOND_DEF = 17;
  localparam int SHL_THIRD_DEF = 5;

  localparam int SLICE_W = 16;
  localparam int RNG_W = 32;
  localparam int STEAL_TRY_LIMIT = 4096;
  localparam int TRY_W = $clog2(STEAL_TRY_LIMIT);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEAL_ENABLE = 1'd1;
  localparam logic [CFG_DATA_W-1:0] WORKER_COUNT_RST = 4'd8;

  typedef enum logic [1:0] {
    ACT_SUBMIT = 2'd0,
    ACT_GET    = 2'd1,
    ACT_ABORT  = 2'd2,
    ACT_SEED   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_WALK,
    S_OWN,
    S_RNG_LD,
    S_MOD,
    S_VIC,
    S_DONE
  } state_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t act;
    logic    submit_ok;
    logic    own_hit;
    logic    steal_ok;
    logic    div_done;
    logic    walk_last;
    logic    victim_hit;
    logic    tries_done;
    logic    out_free;
  } sts_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic sub_div_start;
    logic walk_init;
    logic walk_step;
    logic submit_fin;
    logic own_wr;
    logic rng_first;
    logic rng_adv;
    logic tries_inc;
    logic vic_rd;
    logic vic_wr;
    logic rng_wb;
    logic seed_wr;
    logic abort;
    logic out_load;
  } cmd_t;

endpackage

>>> hdl/wss_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/wss_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by range split and victim choice.
// No package dependency.
module wss_div #(
  parameter int DW = 32,
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [CNT_W-1:0] count;
  logic             busy;
  logic [VW:0]      shifted;
  logic [VW:0]      diff;
  logic             ge;

  assign shifted = {remainder, quotient[DW-1]};
  assign ge = (shifted >= {1'b0, divisor});
  assign diff = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      count <= CNT_W'(DW);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient <= dividend;
    end else if (busy) begin
      remainder <= ge ? diff[VW-1:0] : shifted[VW-1:0];
      quotient <= {quotient[DW-2:0], ge};
    end
  end

endmodule

>>> hdl/wss_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the slice scheduler.
// Depends on wss_pkg for the state, status and command types.
module wss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  wss_pkg::sts_t sts,
  output wss_pkg::cmd_t cmd
);

  wss_pkg::state_t state, state_next;

  assign in_stall = (state != wss_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wss_pkg::S_IDLE: begin
        if (in_valid) state_next = wss_pkg::S_DISPATCH;
      end
      wss_pkg::S_DISPATCH: begin
        unique case (sts.act)
          wss_pkg::ACT_SUBMIT:
            state_next = sts.submit_ok ? wss_pkg::S_DIV : wss_pkg::S_DONE;
          wss_pkg::ACT_GET: begin
            priority if (sts.own_hit) state_next = wss_pkg::S_OWN;
            else if (sts.steal_ok) state_next = wss_pkg::S_RNG_LD;
            else state_next = wss_pkg::S_DONE;
          end
          wss_pkg::ACT_ABORT: state_next = wss_pkg::S_DONE;
          wss_pkg::ACT_SEED: state_next = wss_pkg::S_DONE;
        endcase
      end
      wss_pkg::S_DIV: begin
        if (sts.div_done) state_next = wss_pkg::S_WALK;
      end
      wss_pkg::S_WALK: begin
        if (sts.walk_last) state_next = wss_pkg::S_DONE;
      end
      wss_pkg::S_OWN: state_next = wss_pkg::S_DONE;
      wss_pkg::S_RNG_LD: state_next = wss_pkg::S_MOD;
      wss_pkg::S_MOD: begin
        if (sts.div_done) begin
          priority if (sts.victim_hit) state_next = wss_pkg::S_VIC;
          else if (sts.tries_done) state_next = wss_pkg::S_DONE;
          else state_next = wss_pkg::S_MOD;
        end
      end
      wss_pkg::S_VIC: state_next = wss_pkg::S_DONE;
      wss_pkg::S_DONE: begin
        if (sts.out_free) state_next = wss_pkg::S_IDLE;
      end
      default: state_next = wss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      wss_pkg::S_IDLE: cmd.load_item = in_valid;
      wss_pkg::S_DISPATCH: begin
        unique case (sts.act)
          wss_pkg::ACT_SUBMIT: cmd.sub_div_start = sts.submit_ok;
          wss_pkg::ACT_GET: ;
          wss_pkg::ACT_ABORT: cmd.abort = 1'b1;
          wss_pkg::ACT_SEED: cmd.seed_wr = 1'b1;
        endcase
      end
      wss_pkg::S_DIV: cmd.walk_init = sts.div_done;
      wss_pkg::S_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.submit_fin = sts.walk_last;
      end
      wss_pkg::S_OWN: cmd.own_wr = 1'b1;
      wss_pkg::S_RNG_LD: begin
        cmd.rng_first = 1'b1;
        cmd.rng_adv = 1'b1;
      end
      wss_pkg::S_MOD: begin
        if (sts.div_done) begin
          priority if (sts.victim_hit) begin
            cmd.vic_rd = 1'b1;
          end else if (sts.tries_done) begin
            cmd.rng_wb = 1'b1;
          end else begin
            cmd.tries_inc = 1'b1;
            cmd.rng_adv = 1'b1;
          end
        end
      end
      wss_pkg::S_VIC: begin
        cmd.vic_wr = 1'b1;
        cmd.rng_wb = 1'b1;
      end
      wss_pkg::S_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/wss_dp.sv
`timescale 1ns / 1ps
// Datapath of the slice scheduler: configuration, range and generator stores, divider, results.
// Depends on wss_pkg, wss_ram and wss_div.
module wss_dp #(
  parameter int MAX_WORKERS = wss_pkg::MAX_WORKERS_DEF,
  parameter int SHIFT_LEFT_FIRST = wss_pkg::SHL_FIRST_DEF,
  parameter int SHIFT_RIGHT_SECOND = wss_pkg::SHR_SECOND_DEF,
  parameter int SHIFT_LEFT_THIRD = wss_pkg::SHL_THIRD_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [1:0]                          action,
  input  logic [2:0]                          worker_id,
  input  logic [wss_pkg::SLICE_W-1:0]         range_start,
  input  logic [wss_pkg::SLICE_W-1:0]         range_end,
  input  logic [wss_pkg::RNG_W-1:0]           seed_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                slice_valid,
  output logic [wss_pkg::SLICE_W-1:0]         slice_number,
  output logic                                was_stolen,
  output logic                                accepted,
  output logic [wss_pkg::SLICE_W-1:0]         pending_slices,
  input  wss_pkg::cmd_t                       cmd,
  output wss_pkg::sts_t                       sts
);

  localparam int SW = wss_pkg::SLICE_W;
  localparam int RW = wss_pkg::RNG_W;
  localparam int WI = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CW = $clog2(MAX_WORKERS + 1);
  localparam int TW = wss_pkg::TRY_W;

  // Configuration registers.
  logic [wss_pkg::CFG_DATA_W-1:0] worker_count;
  logic                           steal_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= wss_pkg::WORKER_COUNT_RST;
      steal_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wss_pkg::CFG_WORKER_COUNT: worker_count <= cfg_data;
        wss_pkg::CFG_STEAL_ENABLE: steal_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Active worker count, clamped to 1..MAX_WORKERS.
  logic [CW-1:0]          cnt;
  logic [MAX_WORKERS-1:0] act_mask;

  always_comb begin
    if (worker_count == '0) begin
      cnt = CW'(1);
    end else if (32'(worker_count) > MAX_WORKERS) begin
      cnt = CW'(MAX_WORKERS);
    end else begin
      cnt = CW'(worker_count);
    end
    for (int i = 0; i < MAX_WORKERS; i++) begin
      act_mask[i] = (CW'(i) < cnt);
    end
  end

  // Captured item.
  wss_pkg::action_t    action_q;
  logic [2:0]          wid_q;
  logic [SW-1:0]       rs_q;
  logic [SW-1:0]       re_q;
  logic [RW-1:0]       seed_q;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_q <= wss_pkg::action_t'(action);
      wid_q <= worker_id;
      rs_q <= range_start;
      re_q <= range_end;
      seed_q <= seed_value;
    end
  end

  logic          own;
  logic [WI-1:0] widx;
  logic [WI-1:0] gi;
  logic [SW-1:0] span;

  assign own = (32'(wid_q) < MAX_WORKERS);
  assign widx = WI'(wid_q);
  assign gi = own ? widx : '0;
  assign span = re_q - rs_q;

  // Nonempty flag per worker range, and seeded flag per generator.
  logic [MAX_WORKERS-1:0] nonempty;
  logic [MAX_WORKERS-1:0] seeded;
  logic [SW-1:0]          pending;

  // Shared divider.
  logic          div_start;
  logic [RW-1:0] div_dividend;
  logic          div_done;
  logic [RW-1:0] div_quot;
  logic [CW-1:0] div_rem;

  // Generator.
  logic [RW-1:0] x_q;
  logic [RW-1:0] rng_rdata;
  logic [RW-1:0] rng_src;
  logic [RW-1:0] t1, t2, x_next;
  logic [TW-1:0] tries;

  assign rng_src = cmd.rng_first ? (seeded[gi] ? rng_rdata : RW'(1)) : x_q;
  assign t1 = rng_src ^ (rng_src << SHIFT_LEFT_FIRST);
  assign t2 = t1 ^ (t1 >> SHIFT_RIGHT_SECOND);
  assign x_next = t2 ^ (t2 << SHIFT_LEFT_THIRD);

  assign div_start = cmd.sub_div_start | cmd.rng_adv;
  assign div_dividend = cmd.rng_adv ? x_next : RW'(span);

  wss_div #(
    .DW(RW),
    .VW(CW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_dividend),
    .divisor(cnt),
    .done(div_done),
    .quotient(div_quot),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.rng_adv) begin
      x_q <= x_next;
    end
    if (cmd.rng_first) begin
      tries <= '0;
    end else if (cmd.tries_inc) begin
      tries <= tries + TW'(1);
    end
  end

  logic          rng_we;
  logic [WI-1:0] rng_waddr;
  logic [RW-1:0] rng_wdata;

  assign rng_we = (cmd.seed_wr & own) | cmd.rng_wb;
  assign rng_waddr = cmd.rng_wb ? gi : widx;
  assign rng_wdata = cmd.rng_wb ? x_q : seed_q;

  wss_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_WORKERS),
    .AW(WI)
  ) u_rng_ram (
    .clk(clk),
    .we(rng_we),
    .waddr(rng_waddr),
    .wdata(rng_wdata),
    .raddr(gi),
    .rdata(rng_rdata)
  );

  // Range store: front in the upper half, back in the lower half.
  logic [WI-1:0]   vidx;
  logic [WI-1:0]   v_q;
  logic [WI-1:0]   walk_idx;
  logic [SW-1:0]   per;
  logic [CW-1:0]   left;
  logic [SW-1:0]   pos;
  logic [SW-1:0]   take;
  logic [SW-1:0]   pos_end;
  logic [2*SW-1:0] rng_rd_range;
  logic [SW-1:0]   rd_front, rd_back;
  logic [SW-1:0]   own_front_next, vic_back_next;
  logic            range_we;
  logic [WI-1:0]   range_waddr;
  logic [2*SW-1:0] range_wdata;
  logic [WI-1:0]   range_raddr;

  assign vidx = WI'(div_rem);
  assign take = per + SW'(left != '0);
  assign pos_end = pos + take;
  assign rd_front = rng_rd_range[2*SW-1:SW];
  assign rd_back = rng_rd_range[SW-1:0];
  assign own_front_next = rd_front + SW'(1);
  assign vic_back_next = rd_back - SW'(1);
  assign range_raddr = cmd.vic_rd ? vidx : widx;

  always_comb begin
    range_we = cmd.walk_step | cmd.own_wr | cmd.vic_wr;
    priority if (cmd.walk_step) begin
      range_waddr = walk_idx;
      range_wdata = {pos, pos_end};
    end else if (cmd.own_wr) begin
      range_waddr = widx;
      range_wdata = {own_front_next, rd_back};
    end else begin
      range_waddr = v_q;
      range_wdata = {rd_front, vic_back_next};
    end
  end

  wss_ram #(
    .WIDTH(2 * SW),
    .DEPTH(MAX_WORKERS),
    .AW(WI)
  ) u_range_ram (
    .clk(clk),
    .we(range_we),
    .waddr(range_waddr),
    .wdata(range_wdata),
    .raddr(range_raddr),
    .rdata(rng_rd_range)
  );

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      per <= div_quot[SW-1:0];
      left <= div_rem;
      pos <= rs_q;
      walk_idx <= '0;
    end else if (cmd.walk_step) begin
      pos <= pos_end;
      if (left != '0) left <= left - CW'(1);
      walk_idx <= walk_idx + WI'(1);
    end
    if (cmd.vic_rd) begin
      v_q <= vidx;
    end
  end

  // Control state: flags and pending count.
  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
      seeded <= '0;
      pending <= '0;
    end else begin
      if (cmd.abort || cmd.walk_init) begin
        nonempty <= '0;
      end else if (cmd.walk_step) begin
        nonempty[walk_idx] <= (take != '0);
      end else if (cmd.own_wr) begin
        nonempty[widx] <= (own_front_next < rd_back);
      end else if (cmd.vic_wr) begin
        nonempty[v_q] <= (rd_front < vic_back_next);
      end

      if (cmd.seed_wr && own) begin
        seeded[widx] <= 1'b1;
      end else if (cmd.rng_wb) begin
        seeded[gi] <= 1'b1;
      end

      priority if (cmd.abort) begin
        pending <= '0;
      end else if (cmd.submit_fin) begin
        pending <= span;
      end else if ((cmd.own_wr || cmd.vic_wr) && pending != '0) begin
        pending <= pending - SW'(1);
      end
    end
  end

  // Result of the item in flight.
  logic          r_valid;
  logic [SW-1:0] r_num;
  logic          r_stolen;
  logic          r_acc;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      r_valid <= 1'b0;
      r_num <= '0;
      r_stolen <= 1'b0;
      r_acc <= 1'b0;
    end else if (cmd.submit_fin) begin
      r_acc <= 1'b1;
    end else if (cmd.own_wr) begin
      r_valid <= 1'b1;
      r_num <= rd_front;
    end else if (cmd.vic_wr) begin
      r_valid <= 1'b1;
      r_num <= vic_back_next;
      r_stolen <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      slice_valid <= r_valid;
      slice_number <= r_num;
      was_stolen <= r_stolen;
      accepted <= r_acc;
      pending_slices <= pending;
    end
  end

  always_comb begin
    sts.act = action_q;
    sts.submit_ok = (pending == '0) && (re_q > rs_q);
    sts.own_hit = own && nonempty[widx];
    sts.steal_ok = steal_enable && (pending != '0) && ((nonempty & act_mask) != '0);
    sts.div_done = div_done;
    sts.walk_last = (CW'(walk_idx) == cnt - CW'(1));
    sts.victim_hit = nonempty[vidx];
    sts.tries_done = (tries == TW'(wss_pkg::STEAL_TRY_LIMIT - 1));
    sts.out_free = !out_valid || !out_stall;
  end

endmodule

>>> hdl/work_stealing_slice_scheduler.sv
`timescale 1ns / 1ps
// Top level of the work-stealing slice scheduler: controller plus datapath.
// Depends on wss_pkg, wss_ctrl and wss_dp (which holds wss_ram and wss_div).
//
//   Channel  Direction  Handshake           Content
//   config   in         cfg_we              cfg_index, cfg_data (worker_count, steal_enable)
//   item     in         in_valid/in_stall   action, worker_id, range_start, range_end, seed_value
//   result   out        out_valid/out_stall slice_valid, slice_number, was_stolen, accepted,
//                                           pending_slices
//
// One transaction is processed at a time. An abort, a seed, a rejected submit or a get
// with nothing to hand out goes through dispatch to done; a get from the worker's own range
// adds one range write. An accepted submit divides the span in the shared restoring
// divider, then makes one range write per active worker. A steal loads the generator,
// then each victim attempt runs x mod the active worker count through the same divider;
// at most 4096 attempts are made.
// Reset is synchronous, marks all ranges empty and clears the pending count and generator
// seeded flags (generators read as 1 until seeded); there is no clearing pass.
// The result sits in an output register, so a new item transaction is taken while the
// previous result is stalled; the block only waits at the end of an item when the
// output register is still full and stalled.
module work_stealing_slice_scheduler #(
  parameter int MAX_WORKERS = wss_pkg::MAX_WORKERS_DEF,
  parameter int SHIFT_LEFT_FIRST = wss_pkg::SHL_FIRST_DEF,
  parameter int SHIFT_RIGHT_SECOND = wss_pkg::SHR_SECOND_DEF,
  parameter int SHIFT_LEFT_THIRD = wss_pkg::SHL_THIRD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     action,
  input  logic [2:0]                     worker_id,
  input  logic [wss_pkg::SLICE_W-1:0]    range_start,
  input  logic [wss_pkg::SLICE_W-1:0]    range_end,
  input  logic [wss_pkg::RNG_W-1:0]      seed_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           slice_valid,
  output logic [wss_pkg::SLICE_W-1:0]    slice_number,
  output logic                           was_stolen,
  output logic                           accepted,
  output logic [wss_pkg::SLICE_W-1:0]    pending_slices
);

  // The controller sequences each item; the datapath owns every store and the divider.
  wss_pkg::cmd_t cmd;
  wss_pkg::sts_t sts;

  wss_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts(sts),
    .cmd(cmd)
  );

  wss_dp #(
    .MAX_WORKERS(MAX_WORKERS),
    .SHIFT_LEFT_FIRST(SHIFT_LEFT_FIRST),
    .SHIFT_RIGHT_SECOND(SHIFT_RIGHT_SECOND),
    .SHIFT_LEFT_THIRD(SHIFT_LEFT_THIRD)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .action(action),
    .worker_id(worker_id),
    .range_start(range_start),
    .range_end(range_end),
    .seed_value(seed_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .slice_valid(slice_valid),
    .slice_number(slice_number),
    .was_stolen(was_stolen),
    .accepted(accepted),
    .pending_slices(pending_slices),
    .cmd(cmd),
    .sts(sts)
  );

endmodule

>>> hdl/wss_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the slice scheduler, bound to the top level.
// Depends on wss_pkg and work_stealing_slice_scheduler.
module wss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           slice_valid,
  input logic [wss_pkg::SLICE_W-1:0]    slice_number,
  input logic                           was_stolen,
  input logic                           accepted,
  input logic [wss_pkg::SLICE_W-1:0]    pending_slices
);

  // After reset no result is shown and an item can be taken.
  a_reset_clean: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // One item at a time: a taken item holds off the next.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item taken while another is in flight");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(slice_number)
      && $stable(pending_slices))
    else $error("stalled result changed");

  // A stolen slice is a delivered slice and never a submit.
  a_stolen_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_stolen) |-> slice_valid && !accepted)
    else $error("stolen flag without a slice");

  // No slice means a zero slice number.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !slice_valid) |-> slice_number == '0)
    else $error("slice number set without a slice");

endmodule

bind work_stealing_slice_scheduler wss_checker u_wss_checker (.*);
